/* rtl/mpeg_audio_frame_sync_finder_defines.svh */
// ----------------------------------------------------------------------------
// mpeg audio frame sync finder assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MPEG_AUDIO_FRAME_SYNC_FINDER_DEFINES_SVH
`define MPEG_AUDIO_FRAME_SYNC_FINDER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MAFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MAFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MAFS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MAFS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/mafs_pkg.sv */
// ----------------------------------------------------------------------------
// mafs_pkg
// shared types, header field codes and rate tables of the frame sync finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mafs_pkg;

    // header field codes
    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam logic [7:0]  SYNC_MASK  = 8'hE0;
    localparam logic [1:0]  VER_RSVD   = 2'd1;
    localparam logic [1:0]  VER_MPEG1  = 2'd3;
    localparam logic [1:0]  LAYER_III  = 2'd1;
    localparam logic [1:0]  SRI_RSVD   = 2'd3;
    localparam logic [1:0]  MODE_MONO  = 2'd3;
    localparam logic [3:0]  BRI_FREE   = 4'd0;
    localparam logic [3:0]  BRI_BAD    = 4'd15;

    // frame constants
    localparam logic [17:0] COEF_MPEG1 = 18'd144000;
    localparam logic [17:0] COEF_MPEG2 = 18'd72000;
    localparam logic [10:0] SPF_MPEG1  = 11'd1152;
    localparam logic [10:0] SPF_MPEG2  = 11'd576;
    localparam logic [1:0]  CH_MONO    = 2'd1;
    localparam logic [1:0]  CH_STEREO  = 2'd2;

    // classified header passed from front to back
    typedef struct packed {
        logic       found;
        logic [1:0] ver;
        logic [3:0] bri;
        logic [1:0] sri;
        logic       pad;
        logic [1:0] mode;
    } t_hdr;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic [1:0]  chan;
        logic [10:0] spf;
        logic [10:0] fsz;
        logic [8:0]  kbps;
        logic [15:0] rate;
        logic [31:0] offset;
        logic        found;
    } t_result;

    // sample rate from version and rate index
    function automatic logic [15:0] f_rate(input logic [1:0] ver, input logic [1:0] sri);
        logic [15:0] v;
        v = 16'd0;
        case (ver)
            2'd0: begin
                case (sri)
                    2'd0:    v = 16'd11025;
                    2'd1:    v = 16'd12000;
                    2'd2:    v = 16'd8000;
                    default: v = 16'd0;
                endcase
            end
            2'd2: begin
                case (sri)
                    2'd0:    v = 16'd22050;
                    2'd1:    v = 16'd24000;
                    2'd2:    v = 16'd16000;
                    default: v = 16'd0;
                endcase
            end
            2'd3: begin
                case (sri)
                    2'd0:    v = 16'd44100;
                    2'd1:    v = 16'd48000;
                    2'd2:    v = 16'd32000;
                    default: v = 16'd0;
                endcase
            end
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    // layer iii bitrate in kbit/s
    function automatic logic [8:0] f_kbps(input logic mpeg1, input logic [3:0] bri);
        logic [8:0] v;
        v = 9'd0;
        if (mpeg1) begin
            case (bri)
                4'd1:    v = 9'd32;
                4'd2:    v = 9'd40;
                4'd3:    v = 9'd48;
                4'd4:    v = 9'd56;
                4'd5:    v = 9'd64;
                4'd6:    v = 9'd80;
                4'd7:    v = 9'd96;
                4'd8:    v = 9'd112;
                4'd9:    v = 9'd128;
                4'd10:   v = 9'd160;
                4'd11:   v = 9'd192;
                4'd12:   v = 9'd224;
                4'd13:   v = 9'd256;
                4'd14:   v = 9'd320;
                default: v = 9'd0;
            endcase
        end else begin
            case (bri)
                4'd1:    v = 9'd8;
                4'd2:    v = 9'd16;
                4'd3:    v = 9'd24;
                4'd4:    v = 9'd32;
                4'd5:    v = 9'd40;
                4'd6:    v = 9'd48;
                4'd7:    v = 9'd56;
                4'd8:    v = 9'd64;
                4'd9:    v = 9'd80;
                4'd10:   v = 9'd96;
                4'd11:   v = 9'd112;
                4'd12:   v = 9'd128;
                4'd13:   v = 9'd144;
                4'd14:   v = 9'd160;
                default: v = 9'd0;
            endcase
        end
        return v;
    endfunction

endpackage

/* rtl/mpeg_audio_frame_sync_finder.sv */
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync_finder
// locates the first layer iii frame header in a byte stream and reports it
// ----------------------------------------------------------------------------
// throughput: one byte beat per cycle, input stalls only while the queue holds two results
// a result beat follows the byte ending the search through the queue, the multiply
//   state and the 11-step divider; the divider is skipped when nothing was found
// a second search may start at once; the two-entry queue holds its result
// reset: synchronous active low, block idles until a byte with search start
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpeg_audio_frame_sync_finder #(
    parameter int SEARCH_LIMIT = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] search_start
    input  logic        s_tlast,    // stream_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // [0] found, [32:1] sync_offset,
                                    // [48:33] srate, [57:49] kbit_rate,
                                    // [68:58] frame_len,
                                    // [79:69] frame_samples,
                                    // [81:80] chan_num, [87:82] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mafs_pkg::*;

    localparam int       CNT_W    = $clog2(SEARCH_LIMIT + 4);
    localparam int       QW       = $bits(t_hdr) + CNT_W;
    localparam logic     REG_BASE = 1'b0;

    logic [30:0]      r_base;
    t_qstat           w_qstat;
    logic             w_push;
    t_hdr             w_hdr_in;
    logic [CNT_W-1:0] w_idx_in;
    logic [QW-1:0]    w_qout;
    t_hdr             w_hdr_out;
    logic [CNT_W-1:0] w_idx_out;
    logic             w_pop;
    t_result          w_res;

    // configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BASE) ? {1'b0, r_base} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 31'd0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_BASE)) begin
            r_base <= pwdata[30:0];
        end
    end

    // front: window and classification
    mafs_front #(
        .SEARCH_LIMIT(SEARCH_LIMIT),
        .CNT_W(CNT_W)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_tvalid),
        .o_ready(s_tready),
        .i_byte(s_tdata),
        .i_start(s_tuser),
        .i_end(s_tlast),
        .i_qstat(w_qstat),
        .o_push(w_push),
        .o_hdr(w_hdr_in),
        .o_idx(w_idx_in)
    );

    // descriptor queue
    mafs_queue #(
        .W(QW)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(w_push),
        .i_data({w_hdr_in, w_idx_in}),
        .i_pop(w_pop),
        .o_data(w_qout),
        .o_qstat(w_qstat)
    );

    assign w_hdr_out = w_qout[QW-1:CNT_W];
    assign w_idx_out = w_qout[CNT_W-1:0];

    // back: frame arithmetic and result beat
    mafs_back #(
        .IDX_W(CNT_W)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_qstat(w_qstat),
        .i_hdr(w_hdr_out),
        .i_idx(w_idx_out),
        .o_pop(w_pop),
        .i_base(r_base),
        .o_valid(m_tvalid),
        .i_ready(m_tready),
        .o_res(w_res)
    );

    assign m_tdata = {6'd0, w_res};

endmodule

/* rtl/mafs_front.sv */
// ----------------------------------------------------------------------------
// mafs_front
// byte window, search counter and header classification, one byte per cycle while the queue has room
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mafs_front #(
    parameter int SEARCH_LIMIT = 65536,
    parameter int CNT_W        = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_start,
    input  logic                 i_end,
    input  mafs_pkg::t_qstat     i_qstat,
    output logic                 o_push,
    output mafs_pkg::t_hdr       o_hdr,
    output logic [CNT_W-1:0]     o_idx
);
    import mafs_pkg::*;

    localparam logic [CNT_W-1:0] WIN_N  = CNT_W'(4);
    localparam logic [CNT_W-1:0] LAST_N = CNT_W'(SEARCH_LIMIT + 3);

    logic [23:0]      r_win;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic             w_acc;
    logic             w_active;
    logic [23:0]      w_win;
    logic [CNT_W-1:0] w_n;
    logic             w_full_win;
    logic [7:0]       w_b0;
    logic [7:0]       w_b1;
    logic [7:0]       w_b2;
    logic             w_valid_hdr;
    logic             w_hit;
    logic             w_finish;

    // a beat is taken whenever the queue has room
    assign o_ready = !i_qstat.full;
    assign w_acc   = i_valid && !i_qstat.full;

    // search start clears the window and count in the same beat
    always_comb begin
        w_active   = i_start || !r_done;
        w_win      = i_start ? 24'd0 : r_win;
        w_n        = (i_start ? '0 : r_cnt) + CNT_W'(1);
        w_full_win = (w_n >= WIN_N);
        w_b0       = w_win[23:16];
        w_b1       = w_win[15:8];
        w_b2       = w_win[7:0];
    end

    // header classification
    always_comb begin
        w_valid_hdr = (w_b0 == SYNC_BYTE) && ((w_b1 & SYNC_MASK) == SYNC_MASK)
                   && (w_b1[4:3] != VER_RSVD) && (w_b1[2:1] == LAYER_III)
                   && (w_b2[7:4] != BRI_FREE) && (w_b2[7:4] != BRI_BAD)
                   && (w_b2[3:2] != SRI_RSVD);
        w_hit       = w_full_win && w_valid_hdr;
        w_finish    = !w_hit && ((w_full_win && (w_n >= LAST_N)) || i_end);
    end

    // descriptor to the queue
    assign o_push     = w_acc && w_active && (w_hit || w_finish);
    assign o_hdr.found = w_hit;
    assign o_hdr.ver  = w_b1[4:3];
    assign o_hdr.bri  = w_b2[7:4];
    assign o_hdr.sri  = w_b2[3:2];
    assign o_hdr.pad  = w_b2[1];
    assign o_hdr.mode = i_byte[7:6];
    assign o_idx      = w_n - WIN_N;

    // window and search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= 24'd0;
            r_cnt  <= '0;
            r_done <= 1'b1;
        end else if (w_acc && w_active) begin
            r_win  <= {w_win[15:0], i_byte};
            r_cnt  <= w_n;
            r_done <= w_hit || w_finish;
        end
    end

endmodule

/* rtl/mafs_queue.sv */
// ----------------------------------------------------------------------------
// mafs_queue
// two-entry descriptor queue between the front and the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mafs_queue #(
    parameter int W = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [W-1:0]     i_data,
    input  logic             i_pop,
    output logic [W-1:0]     o_data,
    output mafs_pkg::t_qstat o_qstat
);
    import mafs_pkg::*;

    logic [W-1:0] r_mem [0:1];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_wr;
    logic         w_rd;

    assign o_qstat.full  = (r_cnt == 2'd2);
    assign o_qstat.empty = (r_cnt == 2'd0);
    assign w_wr          = i_push && !o_qstat.full;
    assign w_rd          = i_pop && !o_qstat.empty;
    assign o_data        = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/mafs_back.sv */
// ----------------------------------------------------------------------------
// mafs_back
// rate lookup, frame size multiply and divide, result output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mpeg_audio_frame_sync_finder_defines.svh"

module mafs_back #(
    parameter int IDX_W = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mafs_pkg::t_qstat  i_qstat,
    input  mafs_pkg::t_hdr    i_hdr,
    input  logic [IDX_W-1:0]  i_idx,
    output logic              o_pop,
    input  logic [30:0]       i_base,
    output logic              o_valid,
    input  logic              i_ready,
    output mafs_pkg::t_result o_res
);
    import mafs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    localparam logic [3:0] TOP_BIT = 4'd10;

    t_state           r_state;
    t_hdr             r_hdr;
    logic [IDX_W-1:0] r_idx;
    t_result          r_res;
    logic [25:0]      r_rem;
    logic [15:0]      r_rate;
    logic [10:0]      r_q;
    logic [3:0]       r_bit;

    logic             w_mpeg1;
    logic [15:0]      w_rate;
    logic [8:0]       w_kbps;
    logic [17:0]      w_coef;
    logic [26:0]      w_prod;
    logic [26:0]      w_sh;
    logic             w_ge;
    logic [25:0]      n_rem;
    logic [10:0]      n_q;

    // table lookups and product of the held header
    always_comb begin
        w_mpeg1 = (r_hdr.ver == VER_MPEG1);
        w_rate  = f_rate(r_hdr.ver, r_hdr.sri);
        w_kbps  = f_kbps(w_mpeg1, r_hdr.bri);
        w_coef  = w_mpeg1 ? COEF_MPEG1 : COEF_MPEG2;
        w_prod  = w_coef * w_kbps;
    end

    // one quotient bit per cycle, quotient fits in eleven bits
    always_comb begin
        w_sh  = 27'(r_rate) << r_bit;
        w_ge  = ({1'b0, r_rem} >= w_sh);
        n_rem = w_ge ? (r_rem - w_sh[25:0]) : r_rem;
        n_q   = r_q;
        n_q[r_bit] = w_ge;
    end

    assign o_pop   = (r_state == S_IDLE) && !i_qstat.empty;
    assign o_valid = (r_state == S_OUT);
    assign o_res   = r_res;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= r_hdr.found ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (r_bit == 4'd0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_hdr <= i_hdr;
                r_idx <= i_idx;
            end
            S_MUL: begin
                r_rem  <= w_prod[25:0];
                r_rate <= w_rate;
                r_q    <= 11'd0;
                r_bit  <= TOP_BIT;
                if (r_hdr.found) begin
                    r_res.found  <= 1'b1;
                    r_res.offset <= 32'(i_base) + 32'(r_idx);
                    r_res.rate   <= w_rate;
                    r_res.kbps   <= w_kbps;
                    r_res.fsz    <= 11'd0;
                    r_res.spf    <= w_mpeg1 ? SPF_MPEG1 : SPF_MPEG2;
                    r_res.chan   <= (r_hdr.mode == MODE_MONO) ? CH_MONO : CH_STEREO;
                end else begin
                    r_res <= '0;
                end
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_bit <= r_bit - 4'd1;
                if (r_bit == 4'd0) begin
                    r_res.fsz <= n_q + 11'(r_hdr.pad);
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // checks
    `MAFS_ASSERT_IMP(a_notfound_zero, i_clk, i_rst_n, o_valid && !r_res.found, (r_res.offset == 32'd0) && (r_res.rate == 16'd0) && (r_res.kbps == 9'd0) && (r_res.fsz == 11'd0) && (r_res.spf == 11'd0) && (r_res.chan == 2'd0))
    `MAFS_ASSERT_IMP(a_div_range, i_clk, i_rst_n, r_state == S_DIV, r_bit <= TOP_BIT)
    `MAFS_ASSERT_NXT(a_pop_to_mul, i_clk, i_rst_n, o_pop, r_state == S_MUL)
    `MAFS_ASSERT_IMP(a_found_spf, i_clk, i_rst_n, o_valid && r_res.found, (r_res.spf == SPF_MPEG1) || (r_res.spf == SPF_MPEG2))

endmodule
